// File: src/srq_pkg.sv
package srq_pkg;

  localparam int SRQ_DEPTH    = 64;
  localparam int SRQ_SEQ_BITS = 16;
  localparam int TAG_BITS     = 6;
  localparam int STATUS_BITS  = 3;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DEQUEUED  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOMATCH   = 3'd4;

  localparam logic [1:0] IDX_HOLD = 2'd0;
  localparam logic [1:0] IDX_ZERO = 2'd1;
  localparam logic [1:0] IDX_LAST = 2'd2;
  localparam logic [1:0] IDX_DEC  = 2'd3;

  localparam logic [1:0] POS_HOLD    = 2'd0;
  localparam logic [1:0] POS_ZERO    = 2'd1;
  localparam logic [1:0] POS_IDX_INC = 2'd2;

  typedef struct packed {
    logic                   load;
    logic [1:0]             idx_op;
    logic [1:0]             pos_op;
    logic                   shift_wr;
    logic                   put_wr;
    logic                   pop;
    logic                   res_load;
    logic [STATUS_BITS-1:0] res_code;
  } srq_cmd_t;

  typedef struct packed {
    logic deq;
    logic empty;
    logic full;
    logic seq_eq;
    logic seq_lt;
    logic idx_zero;
    logic idx_at_pos;
    logic idx_is_last;
  } srq_stat_t;

endpackage

// File: src/sorted_reorder_queue.sv
// Channel   Dir  Signals                        Contents
// s_axis    in   tvalid tready tdata tuser      request: cmd, seq, tag
// m_axis    out  tvalid tready tdata tuser      result: status, out_seq, out_tag
//
// One request at a time; s_axis_tready is high only while idle.
// Full-queue inserts and empty-queue dequeues answer from the decide state; a dequeue
// checks the head entry; an insert scans down from the tail (a duplicate ends it), moves
// larger entries up a slot and writes the new entry. The result waits out output stalls.
// Synchronous reset empties the queue; entry contents are kept.
module sorted_reorder_queue
  import srq_pkg::*;
#(
  parameter int DEPTH    = SRQ_DEPTH,
  parameter int SEQ_BITS = SRQ_SEQ_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // seq [SEQ_BITS-1:0], tag, zero pad
  input  logic [((SEQ_BITS+TAG_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // cmd
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // out_seq [SEQ_BITS-1:0], out_tag, zero pad
  output logic [((SEQ_BITS+TAG_BITS+7)/8)*8-1:0]  m_axis_tdata,
  // status
  output logic [STATUS_BITS-1:0]                  m_axis_tuser
);

  localparam int DATA_W = ((SEQ_BITS + TAG_BITS + 7) / 8) * 8;

  srq_cmd_t  cmd;
  srq_stat_t stat;

  logic [SEQ_BITS-1:0] out_seq;
  logic [TAG_BITS-1:0] out_tag;

  srq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  srq_datapath #(
    .DEPTH    (DEPTH),
    .SEQ_BITS (SEQ_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_cmd  (s_axis_tuser),
    .in_seq  (s_axis_tdata[SEQ_BITS-1:0]),
    .in_tag  (s_axis_tdata[SEQ_BITS+TAG_BITS-1:SEQ_BITS]),
    .cmd     (cmd),
    .stat    (stat),
    .status  (m_axis_tuser),
    .out_seq (out_seq),
    .out_tag (out_tag)
  );

  assign m_axis_tdata = DATA_W'({out_tag, out_seq});

endmodule

// File: src/srq_ctrl.sv
module srq_ctrl
  import srq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  input  srq_stat_t stat,
  output srq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DQ_CHK = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_RESP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.pos_op   = POS_HOLD;
    cmd.res_code = ST_INSERTED;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.deq) begin
          if (stat.empty) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_NOMATCH;
            state_next   = S_RESP;
          end else begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_DQ_CHK;
          end
        end else if (stat.full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_RESP;
        end else if (stat.empty) begin
          cmd.pos_op = POS_ZERO;
          state_next = S_PUT;
        end else begin
          cmd.idx_op = IDX_LAST;
          state_next = S_SCAN;
        end
      end
      S_DQ_CHK: begin
        cmd.res_load = 1'b1;
        if (stat.seq_eq) begin
          cmd.pop      = 1'b1;
          cmd.res_code = ST_DEQUEUED;
        end else begin
          cmd.res_code = ST_NOMATCH;
        end
        state_next = S_RESP;
      end
      S_SCAN: begin
        if (stat.seq_eq) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_DUPLICATE;
          state_next   = S_RESP;
        end else if (stat.seq_lt) begin
          cmd.pos_op = POS_IDX_INC;
          if (stat.idx_is_last) begin
            state_next = S_PUT;
          end else begin
            cmd.idx_op = IDX_LAST;
            state_next = S_SHIFT;
          end
        end else if (stat.idx_zero) begin
          cmd.pos_op = POS_ZERO;
          cmd.idx_op = IDX_LAST;
          state_next = S_SHIFT;
        end else begin
          cmd.idx_op = IDX_DEC;
        end
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (stat.idx_at_pos) begin
          state_next = S_PUT;
        end else begin
          cmd.idx_op = IDX_DEC;
        end
      end
      S_PUT: begin
        cmd.put_wr   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_INSERTED;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/srq_datapath.sv
module srq_datapath
  import srq_pkg::*;
#(
  parameter int DEPTH    = SRQ_DEPTH,
  parameter int SEQ_BITS = SRQ_SEQ_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_cmd,
  input  logic [SEQ_BITS-1:0]    in_seq,
  input  logic [TAG_BITS-1:0]    in_tag,
  input  srq_cmd_t               cmd,
  output srq_stat_t              stat,
  output logic [STATUS_BITS-1:0] status,
  output logic [SEQ_BITS-1:0]    out_seq,
  output logic [TAG_BITS-1:0]    out_tag
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = SEQ_BITS + TAG_BITS;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata;

  logic                cur_cmd;
  logic [SEQ_BITS-1:0] cur_seq;
  logic [TAG_BITS-1:0] cur_tag;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] idx_inc;

  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [ENT_W-1:0] wdata;
  logic             we;

  logic [SEQ_BITS-1:0] rd_seq;
  logic [TAG_BITS-1:0] rd_tag;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign rd_seq  = rdata[ENT_W-1:TAG_BITS];
  assign rd_tag  = rdata[TAG_BITS-1:0];
  assign idx_inc = idx + IDX_W'(1);

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO: idx_next = '0;
      IDX_LAST: idx_next = IDX_W'(count - CNT_W'(1));
      IDX_DEC:  idx_next = idx - IDX_W'(1);
      default:  idx_next = idx;
    endcase
  end

  assign raddr = phys(head, idx_next);
  assign we    = cmd.shift_wr | cmd.put_wr;
  assign waddr = cmd.shift_wr ? phys(head, idx_inc) : phys(head, pos);
  assign wdata = cmd.shift_wr ? rdata : {cur_seq, cur_tag};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd <= in_cmd;
      cur_seq <= in_seq;
      cur_tag <= in_tag;
    end
    idx <= idx_next;
    case (cmd.pos_op)
      POS_ZERO:    pos <= '0;
      POS_IDX_INC: pos <= idx_inc;
      default:     pos <= pos;
    endcase
    if (cmd.res_load) begin
      status <= cmd.res_code;
      if (cmd.res_code == ST_DEQUEUED) begin
        out_seq <= rd_seq;
        out_tag <= rd_tag;
      end else begin
        out_seq <= '0;
        out_tag <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.pop) begin
      head  <= (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
      count <= count - CNT_W'(1);
    end else if (cmd.put_wr) begin
      count <= count + CNT_W'(1);
    end
  end

  always_comb begin
    stat.deq         = (cur_cmd == CMD_DEQUEUE);
    stat.empty       = (count == '0);
    stat.full        = (count == CNT_W'(DEPTH));
    stat.seq_eq      = (rd_seq == cur_seq);
    stat.seq_lt      = (rd_seq < cur_seq);
    stat.idx_zero    = (idx == '0);
    stat.idx_at_pos  = (idx == pos);
    stat.idx_is_last = ((CNT_W'(idx) + CNT_W'(1)) == count);
  end

endmodule

// File: test/tb_sorted_reorder_queue.sv
`timescale 1ns / 100ps

module tb_sorted_reorder_queue;
  import srq_pkg::*;

  localparam int SEQ_W          = SRQ_SEQ_BITS;
  localparam int DATA_W         = ((SRQ_SEQ_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SEQ_W-1:0]       seq;
    logic [TAG_BITS-1:0]    tag;
  } result_t;

  typedef struct packed {
    logic                cmd;
    logic [SEQ_W-1:0]    seq;
    logic [TAG_BITS-1:0] tag;
    logic                typed;
    result_t             want;
  } request_row_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic              s_axis_tuser  = CMD_INSERT;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [STATUS_BITS-1:0] m_axis_tuser;

  logic [SEQ_W-1:0]    held_seq[$];
  logic [TAG_BITS-1:0] held_tag[$];
  result_t             pending_results[$];
  int                  errors     = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  logic [8:0]          stall_clock = '0;

  request_row_t directed_rows [0:18] = '{
    '{CMD_DEQUEUE, 16'h0000, 6'd63, 1'b1, '{ST_NOMATCH,  16'h0000, 6'd0}},
    '{CMD_INSERT,  16'hFFFF, 6'd63, 1'b1, '{ST_INSERTED, 16'h0000, 6'd0}},
    '{CMD_INSERT,  16'h0000, 6'd0,  1'b1, '{ST_INSERTED, 16'h0000, 6'd0}},
    '{CMD_INSERT,  16'h0000, 6'd21, 1'b1, '{ST_DUPLICATE, 16'h0000, 6'd0}},
    '{CMD_INSERT,  16'hFFFF, 6'd0,  1'b1, '{ST_DUPLICATE, 16'h0000, 6'd0}},
    '{CMD_INSERT,  16'h8000, 6'd42, 1'b1, '{ST_INSERTED, 16'h0000, 6'd0}},
    '{CMD_DEQUEUE, 16'h8000, 6'd0,  1'b1, '{ST_NOMATCH,  16'h0000, 6'd0}},
    '{CMD_DEQUEUE, 16'hFFFF, 6'd0,  1'b1, '{ST_NOMATCH,  16'h0000, 6'd0}},
    '{CMD_DEQUEUE, 16'h0000, 6'd63, 1'b1, '{ST_DEQUEUED, 16'h0000, 6'd0}},
    '{CMD_INSERT,  16'h5555, 6'd42, 1'b0, '0},
    '{CMD_INSERT,  16'hAAAA, 6'd21, 1'b0, '0},
    '{CMD_DEQUEUE, 16'h5555, 6'd0,  1'b0, '0},
    '{CMD_DEQUEUE, 16'h7FFF, 6'd0,  1'b0, '0},
    '{CMD_DEQUEUE, 16'h8000, 6'd0,  1'b0, '0},
    '{CMD_DEQUEUE, 16'hAAAA, 6'd0,  1'b0, '0},
    '{CMD_DEQUEUE, 16'hFFFF, 6'd0,  1'b1, '{ST_DEQUEUED, 16'hFFFF, 6'd63}},
    '{CMD_DEQUEUE, 16'hFFFF, 6'd0,  1'b1, '{ST_NOMATCH,  16'h0000, 6'd0}},
    '{CMD_INSERT,  16'h0001, 6'd1,  1'b0, '0},
    '{CMD_DEQUEUE, 16'h0001, 6'd0,  1'b0, '0}
  };

  sorted_reorder_queue u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t reorder_step(input logic c, input logic [SEQ_W-1:0] s,
                                           input logic [TAG_BITS-1:0] t);
    result_t r;
    int      pos;
    r   = '0;
    pos = 0;
    if (c == CMD_INSERT) begin
      if (held_seq.size() >= SRQ_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        while (pos < held_seq.size() && held_seq[pos] < s) pos++;
        if (pos < held_seq.size() && held_seq[pos] == s) begin
          r.status = ST_DUPLICATE;
        end else begin
          held_seq.insert(pos, s);
          held_tag.insert(pos, t);
          r.status = ST_INSERTED;
        end
      end
    end else if (held_seq.size() != 0 && held_seq[0] == s) begin
      r.status = ST_DEQUEUED;
      r.seq    = held_seq.pop_front();
      r.tag    = held_tag.pop_front();
    end else begin
      r.status = ST_NOMATCH;
    end
    return r;
  endfunction

  task automatic send_request(input logic c, input logic [SEQ_W-1:0] s,
                              input logic [TAG_BITS-1:0] t, input logic typed,
                              input result_t want);
    result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= DATA_W'({t, s});
    do @(posedge clk); while (!s_axis_tready);
    predicted = reorder_step(c, s, t);
    pending_results.push_back(typed ? want : predicted);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // receiver: ready, coin flip, sparse, then a fixed on-off beat that follows bit 3 of the stall counter
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1'b1;
    case (stall_clock[8:7])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= stall_clock[3];
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d seq %0h tag %0d",
               m_axis_tuser, m_axis_tdata[SEQ_W-1:0], m_axis_tdata[SEQ_W+TAG_BITS-1:SEQ_W]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[SEQ_W-1:0] != want.seq) begin
          $error("out_seq: expected %0h, got %0h", want.seq, m_axis_tdata[SEQ_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[SEQ_W+TAG_BITS-1:SEQ_W] != want.tag) begin
          $error("out_tag: expected %0d, got %0d", want.tag,
                 m_axis_tdata[SEQ_W+TAG_BITS-1:SEQ_W]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_sorted_reorder_queue: FAIL");
    $finish;
  end

  initial begin
    logic             c;
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] base;
    int               window;
    int               ins_pct;
    int               roll;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].seq, directed_rows[i].tag,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    hold_until_drained();
    for (int phase = 0; phase < PHASES; phase++) begin
      // wide windows with heavy inserts push the queue to full
      case (phase % 3)
        0: begin window = 96; ins_pct = 85; end
        1: begin window = 12; ins_pct = 55; end
        default: begin window = 40; ins_pct = 60; end
      endcase
      base = SEQ_W'($urandom_range(0, 65535));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          c = CMD_INSERT;
          if (roll < 4) s = SEQ_W'($urandom_range(0, 65535));
          else s = SEQ_W'(base + SEQ_W'($urandom_range(0, window)));
        end else begin
          c = CMD_DEQUEUE;
          if (held_seq.size() != 0 && $urandom_range(0, 3) != 0) s = held_seq[0];
          else if ($urandom_range(0, 1) == 1) s = SEQ_W'(base + SEQ_W'($urandom_range(0, window)));
          else s = SEQ_W'($urandom_range(0, 65535));
        end
        send_request(c, s, TAG_BITS'($urandom_range(0, 63)), 1'b0, '0);
      end
      hold_until_drained();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sorted_reorder_queue: PASS");
    end else begin
      $display("tb_sorted_reorder_queue: FAIL");
    end
    $finish;
  end

endmodule
